[rtl/core/assert_macros.svh]
// assertion macros used by the datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// property that must hold in the same cycle whenever the antecedent holds
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/core/fqr_pkg.sv]
// types and constants of the queue with partial reversal
`default_nettype none

package fqr_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned K_W       = 7;
  localparam int unsigned OCC_W     = 7;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 40;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH = 2'd0,
    MODE_POP  = 2'd1,
    MODE_REV  = 2'd2
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_BADK  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP_WAIT,
    S_SWAP_RD,
    S_SWAP_WA,
    S_SWAP_WB,
    S_FINISH
  } state_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_item;
    logic exec;
    logic cap_pop;
    logic swap_rd;
    logic swap_wa;
    logic swap_wb;
    logic out_load;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    mode_e mode;
    logic  full;
    logic  empty;
    logic  bad_k;
    logic  short_k;
    logic  last_swap;
  } flags_t;

endpackage

`default_nettype wire

[rtl/core/fqr_dp.sv]
// datapath: circular store, pointers, swap walker and result registers
`default_nettype none
`include "assert_macros.svh"

module fqr_dp import fqr_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire mode_e               item_mode_i,
  input  wire logic [DATA_W-1:0]   item_value_i,
  input  wire logic [K_W-1:0]      item_k_i,
  input  wire cmd_t                cmd_i,
  output flags_t                   flags_o,
  output logic [DATA_W-1:0]        out_popped_o,
  output status_e                  out_status_o,
  output logic [OCC_W-1:0]         out_occ_o
);

  localparam int unsigned IDXW = $clog2(DEPTH);
  localparam int unsigned FW   = $clog2(DEPTH + 1);
  localparam int unsigned SW   = IDXW + 1;
  localparam int unsigned CW   = (FW > K_W) ? FW : K_W;
  localparam int unsigned CNTW = K_W - 1;
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(DEPTH - 1);
  localparam logic [SW-1:0]   DEPTH_S  = SW'(DEPTH);
  localparam logic [FW-1:0]   DEPTH_F  = FW'(DEPTH);

  logic [DATA_W-1:0] mem_q [DEPTH];

  mode_e             mode_q;
  logic [DATA_W-1:0] value_q;
  logic [K_W-1:0]    k_q;

  logic [IDXW-1:0]   head_q, head_d;
  logic [IDXW-1:0]   tail_q, tail_d;
  logic [FW-1:0]     fill_q, fill_d;
  logic [IDXW-1:0]   a_q, b_q;
  logic [CNTW-1:0]   cnt_q;
  logic [DATA_W-1:0] rd_a_q, rd_b_q;

  logic [DATA_W-1:0] res_popped_q;
  status_e           res_status_q;
  logic [DATA_W-1:0] out_popped_q;
  status_e           out_status_q;
  logic [OCC_W-1:0]  out_occ_q;

  logic              full, empty, bad_k, short_k;
  logic              do_push, do_pop;
  status_e           exec_status;
  logic [SW-1:0]     b_sum, tail_sum;
  logic [IDXW-1:0]   b_start, tail_chk;
  logic [IDXW-1:0]   a_next, b_next;
  logic              wr_en, rd_en;
  logic [IDXW-1:0]   wr_addr, rd_addr_a;
  logic [DATA_W-1:0] wr_data;
  logic [CW-1:0]     fill_ext;

  assign full     = (fill_q == DEPTH_F);
  assign empty    = (fill_q == '0);
  assign bad_k    = (CW'(k_q) > CW'(fill_q));
  assign short_k  = (k_q < K_W'(2));
  assign do_push  = cmd_i.exec && (mode_q == MODE_PUSH) && !full;
  assign do_pop   = cmd_i.exec && (mode_q == MODE_POP) && !empty;

  assign flags_o.mode      = mode_q;
  assign flags_o.full      = full;
  assign flags_o.empty     = empty;
  assign flags_o.bad_k     = bad_k;
  assign flags_o.short_k   = short_k;
  assign flags_o.last_swap = (cnt_q == CNTW'(1));

  // far end of the reversed span, head + k - 1 wrapped
  assign b_sum    = SW'(head_q) + SW'(k_q) - SW'(1);
  assign b_start  = (b_sum >= DEPTH_S) ? IDXW'(b_sum - DEPTH_S) : IDXW'(b_sum);
  assign tail_sum = SW'(head_q) + SW'(fill_q);
  assign tail_chk = (tail_sum >= DEPTH_S) ? IDXW'(tail_sum - DEPTH_S) : IDXW'(tail_sum);
  assign a_next   = (a_q == LAST_IDX) ? '0 : a_q + IDXW'(1);
  assign b_next   = (b_q == '0) ? LAST_IDX : b_q - IDXW'(1);

  always_comb begin
    case (mode_q)
      MODE_PUSH: exec_status = full ? ST_FULL : ST_OK;
      MODE_POP:  exec_status = empty ? ST_EMPTY : ST_OK;
      MODE_REV:  exec_status = bad_k ? ST_BADK : ST_OK;
      default:   exec_status = ST_OK;
    endcase
  end

  // single write port, two registered read ports
  always_comb begin
    wr_en   = do_push || cmd_i.swap_wa || cmd_i.swap_wb;
    wr_addr = tail_q;
    wr_data = value_q;
    if (cmd_i.swap_wa) begin
      wr_addr = a_q;
      wr_data = rd_b_q;
    end else if (cmd_i.swap_wb) begin
      wr_addr = b_q;
      wr_data = rd_a_q;
    end
    rd_en     = cmd_i.exec || cmd_i.swap_rd;
    rd_addr_a = cmd_i.swap_rd ? a_q : head_q;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_q <= mem_q[rd_addr_a];
      rd_b_q <= mem_q[b_q];
    end
  end

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    fill_d = fill_q;
    if (do_push) begin
      tail_d = (tail_q == LAST_IDX) ? '0 : tail_q + IDXW'(1);
      fill_d = fill_q + FW'(1);
    end
    if (do_pop) begin
      head_d = (head_q == LAST_IDX) ? '0 : head_q + IDXW'(1);
      fill_d = fill_q - FW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      fill_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      fill_q <= fill_d;
      if (cmd_i.exec) begin
        cnt_q <= k_q[K_W-1:1];
      end else if (cmd_i.swap_wb) begin
        cnt_q <= cnt_q - CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      mode_q  <= item_mode_i;
      value_q <= item_value_i;
      k_q     <= item_k_i;
    end
    if (cmd_i.exec) begin
      a_q          <= head_q;
      b_q          <= b_start;
      res_status_q <= exec_status;
      res_popped_q <= '0;
    end else if (cmd_i.swap_wb) begin
      a_q <= a_next;
      b_q <= b_next;
    end
    if (cmd_i.cap_pop) begin
      res_popped_q <= rd_a_q;
    end
    if (cmd_i.out_load) begin
      out_popped_q <= res_popped_q;
      out_status_q <= res_status_q;
      out_occ_q    <= fill_ext[OCC_W-1:0];
    end
  end

  assign fill_ext     = CW'(fill_q);
  assign out_popped_o = out_popped_q;
  assign out_status_o = out_status_q;
  assign out_occ_o    = out_occ_q;

  `ASSERT_ALWAYS(a_fill_bound, clk_i, rst_ni, fill_q <= DEPTH_F, "fill count above depth")
  `ASSERT_ALWAYS(a_ptr_match, clk_i, rst_ni, tail_q == tail_chk, "tail not head plus fill")
  `ASSERT_IMPLIES(a_swap_ends, clk_i, rst_ni, cmd_i.swap_wa || cmd_i.swap_wb, a_q != b_q, "swap ends collide")

endmodule

`default_nettype wire

[rtl/core/fqr_ctrl.sv]
// controller: sequences one word through execute, pop read or swap walk, and result
`default_nettype none

module fqr_ctrl import fqr_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   s_valid_i,
  output logic        s_ready_o,
  output logic        m_valid_o,
  input  wire logic   m_ready_i,
  input  wire flags_t flags_i,
  output cmd_t        cmd_o
);

  state_e state_q, state_d;
  logic   m_valid_q, m_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_FINISH;
        if ((flags_i.mode == MODE_POP) && !flags_i.empty) begin
          state_d = S_POP_WAIT;
        end else if ((flags_i.mode == MODE_REV) && !flags_i.bad_k && !flags_i.short_k) begin
          state_d = S_SWAP_RD;
        end
      end
      S_POP_WAIT: begin
        cmd_o.cap_pop = 1'b1;
        state_d       = S_FINISH;
      end
      S_SWAP_RD: begin
        cmd_o.swap_rd = 1'b1;
        state_d       = S_SWAP_WA;
      end
      S_SWAP_WA: begin
        cmd_o.swap_wa = 1'b1;
        state_d       = S_SWAP_WB;
      end
      S_SWAP_WB: begin
        cmd_o.swap_wb = 1'b1;
        state_d       = flags_i.last_swap ? S_FINISH : S_SWAP_RD;
      end
      S_FINISH: begin
        if (!m_valid_q || m_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (cmd_o.out_load) begin
      m_valid_d = 1'b1;
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end
  end

  assign m_valid_o = m_valid_q;

endmodule

`default_nettype wire

[rtl/core/fifo_queue_reverse_first_k_core.sv]
// top level: bounded word queue with push, pop and in-place reversal of the first k words
// a push, rejected or no-op word goes through execute and finish; a pop adds a pop read
// state, and a reversal of k words adds floor(k/2) swaps
// one word at a time: the input is taken again in the cycle after the result is loaded,
// a stalled result holds it off; each swap walks the read, write-a and write-b states
// reset: pointers and fill count clear to empty, the store itself is not cleared
`default_nettype none

module fifo_queue_reverse_first_k_core import fqr_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // input stream
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,  // value[31:0], count_k[38:32], zero pad
  input  wire logic [MODE_W-1:0]    s_axis_tuser,  // mode[1:0]
  // result stream
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0]      m_axis_tdata,  // popped[31:0], occupancy[38:32], zero pad
  output logic [STATUS_W-1:0]       m_axis_tuser   // status[1:0]
);

  cmd_t              cmd;
  flags_t            flags;
  logic [DATA_W-1:0] out_popped;
  status_e           out_status;
  logic [OCC_W-1:0]  out_occ;

  // controller owns both handshakes, datapath only sees commands
  fqr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .flags_i   (flags),
    .cmd_o     (cmd)
  );

  // store, head/tail/fill and the two-pointer swap walker
  fqr_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_mode_i  (mode_e'(s_axis_tuser)),
    .item_value_i (s_axis_tdata[DATA_W-1:0]),
    .item_k_i     (s_axis_tdata[DATA_W+K_W-1:DATA_W]),
    .cmd_i        (cmd),
    .flags_o      (flags),
    .out_popped_o (out_popped),
    .out_status_o (out_status),
    .out_occ_o    (out_occ)
  );

  // pack the result word, pad bits stay zero
  assign m_axis_tdata = {(M_TDATA_W - DATA_W - OCC_W)'(0), out_occ, out_popped};
  assign m_axis_tuser = out_status;

endmodule

`default_nettype wire
